// ===== hdl/allele_profile_pairwise_distance_assert.svh =====
// Assertion macros for the checker file of the pairwise distance block.
// Depends on nothing; include it by its bare file name.
`ifndef ALLELE_PROFILE_PAIRWISE_DISTANCE_ASSERT_SVH
`define ALLELE_PROFILE_PAIRWISE_DISTANCE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define APD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== hdl/apd_pkg.sv =====
// Package for the pairwise allele-profile distance block: sizes, codes and the
// queue item type. Depends on nothing.
package apd_pkg;

    localparam int MAX_PROFILES = 64;
    localparam int MAX_LOCI     = 2048;

    localparam int ALLELE_W = 31;
    localparam int NLOCI_W  = 12;
    localparam int DIST_W   = 12;
    localparam int PROF_W   = $clog2(MAX_PROFILES);
    localparam int PCNT_W   = PROF_W + 1;
    localparam int LOCUS_W  = $clog2(MAX_LOCI);

    localparam int STORE_DEPTH = MAX_PROFILES * MAX_LOCI;

    localparam int DIST_MAX = (1 << DIST_W) - 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Register map.
    localparam int          REG_NUM_LOCI   = 0;
    localparam int          CFG_AW         = 3;
    localparam logic [11:0] NUM_LOCI_RESET = 12'd2048;

    // One classified allele on its way from the front to the back.
    typedef struct packed {
        logic [ALLELE_W-1:0] allele;
        logic [LOCUS_W-1:0]  pos;
        logic [PROF_W-1:0]   prof;
        logic                full;
        logic                new_set;
        logic                complete;
    } apd_item_t;

endpackage

// ===== hdl/apd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module apd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/apd_front.sv =====
// Front end: accepts alleles, tracks locus position and profile count, and
// classifies each allele for the compare engine. Depends on apd_pkg.
module apd_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [apd_pkg::NLOCI_W-1:0]     num_loci,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [apd_pkg::ALLELE_W-1:0]    s_allele,
    input  logic                            s_new_set,
    output logic                            push_valid,
    input  logic                            push_ready,
    output apd_pkg::apd_item_t              push_item
);

    logic [apd_pkg::LOCUS_W-1:0] locus_reg, locus_next;
    logic [apd_pkg::PCNT_W-1:0]  pcount_reg, pcount_next;

    logic [apd_pkg::NLOCI_W-1:0] n_eff;
    logic [apd_pkg::LOCUS_W-1:0] pos_raw;
    logic [apd_pkg::LOCUS_W-1:0] pos;
    logic [apd_pkg::NLOCI_W-1:0] pos_inc;
    logic [apd_pkg::PCNT_W-1:0]  p_cur;
    logic                        full;
    logic                        complete;
    logic                        accept;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;

    // A zero count acts as one locus, anything beyond the store as the maximum.
    always_comb begin
        if (num_loci == '0) begin
            n_eff = apd_pkg::NLOCI_W'(1);
        end else if (num_loci > apd_pkg::NLOCI_W'(apd_pkg::MAX_LOCI)) begin
            n_eff = apd_pkg::NLOCI_W'(apd_pkg::MAX_LOCI);
        end else begin
            n_eff = num_loci;
        end
    end

    always_comb begin
        pos_raw = s_new_set ? '0 : locus_reg;
        p_cur   = s_new_set ? '0 : pcount_reg;
        if (apd_pkg::NLOCI_W'(pos_raw) >= n_eff) begin
            pos = apd_pkg::LOCUS_W'(n_eff - apd_pkg::NLOCI_W'(1));
        end else begin
            pos = pos_raw;
        end
        pos_inc  = apd_pkg::NLOCI_W'(pos) + apd_pkg::NLOCI_W'(1);
        complete = (pos_inc >= n_eff);
        full     = (p_cur >= apd_pkg::PCNT_W'(apd_pkg::MAX_PROFILES));
    end

    always_comb begin
        locus_next  = locus_reg;
        pcount_next = pcount_reg;
        if (accept) begin
            locus_next  = complete ? '0 : apd_pkg::LOCUS_W'(pos_inc);
            pcount_next = (complete && !full) ? p_cur + apd_pkg::PCNT_W'(1) : p_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            locus_reg  <= '0;
            pcount_reg <= '0;
        end else begin
            locus_reg  <= locus_next;
            pcount_reg <= pcount_next;
        end
    end

    always_comb begin
        push_item.allele   = s_allele;
        push_item.pos      = pos;
        push_item.prof     = p_cur[apd_pkg::PROF_W-1:0];
        push_item.full     = full;
        push_item.new_set  = s_new_set;
        push_item.complete = complete;
    end

endmodule

// ===== hdl/apd_queue.sv =====
// Short FIFO of classified alleles between the front end and the compare
// engine. Depends on apd_pkg.
module apd_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  apd_pkg::apd_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output apd_pkg::apd_item_t pop_item
);

    localparam int CNT_W = $clog2(apd_pkg::QUEUE_DEPTH + 1);

    apd_pkg::apd_item_t          mem_reg [apd_pkg::QUEUE_DEPTH];
    logic [apd_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [apd_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = (count_reg != CNT_W'(apd_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + apd_pkg::QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + apd_pkg::QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/apd_back.sv =====
// Compare engine: stores each allele, walks the earlier profiles one per cycle
// unless stalled, updates pair counters, emits distances. Uses apd_pkg, apd_ram.
module apd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  apd_pkg::apd_item_t            pop_item,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [apd_pkg::PROF_W-1:0]    m_newer_index,
    output logic [apd_pkg::PROF_W-1:0]    m_older_index,
    output logic [apd_pkg::DIST_W-1:0]    m_distance,
    output logic                          m_tlast
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;
    localparam int   SAW     = $clog2(apd_pkg::STORE_DEPTH);

    logic                              st_reg, st_next;
    apd_pkg::apd_item_t                cur_reg;
    logic [apd_pkg::PROF_W-1:0]        k_reg, k_next;
    logic                              b_valid_reg, b_valid_next;
    logic [apd_pkg::PROF_W-1:0]        b_k_reg;
    logic                              b_last_reg;
    logic [apd_pkg::MAX_PROFILES-1:0]  ctr_valid_reg, ctr_valid_next;
    logic                              out_valid_reg, out_valid_next;
    logic [apd_pkg::PROF_W-1:0]        out_newer_reg, out_older_reg;
    logic [apd_pkg::DIST_W-1:0]        out_dist_reg;
    logic                              out_last_reg;

    logic                              start;
    logic                              issue;
    logic                              k_last;
    logic                              stall;
    logic                              b_done;
    logic                              load;
    logic [apd_pkg::ALLELE_W-1:0]      st_rdata;
    logic [apd_pkg::DIST_W-1:0]        ctr_rdata;
    logic [apd_pkg::DIST_W-1:0]        cnt;
    logic [apd_pkg::DIST_W-1:0]        cnt_new;
    logic                              differ;

    assign pop_ready = (st_reg == ST_IDLE) && !b_valid_reg;
    assign start     = pop_ready && pop_valid;
    assign stall     = b_valid_reg && cur_reg.complete && out_valid_reg && !m_tready;
    assign issue     = (st_reg == ST_RUN) && !stall;
    assign k_last    = (k_reg == cur_reg.prof - apd_pkg::PROF_W'(1));
    assign b_done    = b_valid_reg && !stall;
    assign load      = b_done && cur_reg.complete;

    apd_ram #(
        .WIDTH (apd_pkg::ALLELE_W),
        .DEPTH (apd_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (start && !pop_item.full),
        .waddr (SAW'({pop_item.prof, pop_item.pos})),
        .wdata (pop_item.allele),
        .re    (issue),
        .raddr (SAW'({k_reg, cur_reg.pos})),
        .rdata (st_rdata)
    );

    apd_ram #(
        .WIDTH (apd_pkg::DIST_W),
        .DEPTH (apd_pkg::MAX_PROFILES)
    ) u_counters (
        .aclk  (aclk),
        .we    (b_done && !cur_reg.complete),
        .waddr (b_k_reg),
        .wdata (cnt_new),
        .re    (issue),
        .raddr (k_reg),
        .rdata (ctr_rdata)
    );

    // A counter whose valid bit is clear reads as zero.
    always_comb begin
        cnt     = ctr_valid_reg[b_k_reg] ? ctr_rdata : '0;
        differ  = (cur_reg.allele != '0) && (st_rdata != '0) && (cur_reg.allele != st_rdata);
        cnt_new = (differ && (cnt != apd_pkg::DIST_W'(apd_pkg::DIST_MAX)))
                  ? cnt + apd_pkg::DIST_W'(1) : cnt;
    end

    always_comb begin
        st_next        = st_reg;
        k_next         = k_reg;
        b_valid_next   = b_valid_reg;
        ctr_valid_next = ctr_valid_reg;
        out_valid_next = out_valid_reg;

        if (start) begin
            if (pop_item.new_set) begin
                ctr_valid_next = '0;
            end
            if (!pop_item.full && (pop_item.prof != '0)) begin
                st_next = ST_RUN;
                k_next  = '0;
            end
        end

        if (issue) begin
            b_valid_next = 1'b1;
            k_next       = k_reg + apd_pkg::PROF_W'(1);
            if (k_last) begin
                st_next = ST_IDLE;
            end
        end else if (b_done) begin
            b_valid_next = 1'b0;
        end

        if (b_done) begin
            ctr_valid_next[b_k_reg] = !cur_reg.complete;
        end

        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            k_reg         <= '0;
            b_valid_reg   <= 1'b0;
            ctr_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            k_reg         <= k_next;
            b_valid_reg   <= b_valid_next;
            ctr_valid_reg <= ctr_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cur_reg <= pop_item;
        end
        if (issue) begin
            b_k_reg    <= k_reg;
            b_last_reg <= k_last;
        end
        if (load) begin
            out_newer_reg <= cur_reg.prof;
            out_older_reg <= b_k_reg;
            out_dist_reg  <= cnt_new;
            out_last_reg  <= b_last_reg;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_newer_index = out_newer_reg;
    assign m_older_index = out_older_reg;
    assign m_distance    = out_dist_reg;
    assign m_tlast       = out_last_reg;

endmodule

// ===== hdl/allele_profile_pairwise_distance.sv =====
// Top level of the pairwise allele-profile distance block: APB register,
// front end, item queue and compare engine. Depends on apd_pkg and its modules.
//
// Usage: alleles stream in on the s_ channel, one locus per transfer, num_loci
// transfers per profile; s_tuser marks the first allele of a new data set and
// clears the profile count and all pair counters. When a profile completes,
// the block sends one transfer per earlier profile on the m_ channel, in
// ascending order of the earlier index, with m_tlast on the final one. The
// first profile of a set completes with no transfers, and once 64 profiles
// are stored further alleles only advance the locus position.
// Throughput: the compare engine reads one stored profile and one pair counter
// per cycle for each earlier profile of an allele, unless a held result stalls
// it, and takes no new allele until it is through with the last. A four-entry
// queue lets the front keep taking alleles while the engine works. A profile's
// last allele passes through the queue, the current-item register and the
// registered RAM reads before its first result is loaded into the result
// register.
// Reset (aresetn low, synchronous) clears the counts, the queue, the counter
// valid bits and the output, and sets num_loci to 2048. The profile store is
// not cleared. A stalled receiver holds the result register and stops the
// engine; the queue then fills and s_tready drops.
module allele_profile_pairwise_distance (
    input  logic                        aclk,
    input  logic                        aresetn,
    // APB configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [apd_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Allele input.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [30:0] allele, [31] zero
    input  logic                        s_tuser,   // [0] new_set
    // Distance results.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // [5:0] newer_index, [11:6] older_index,
                                                   // [23:12] distance
    output logic                        m_tlast
);

    logic [apd_pkg::NLOCI_W-1:0] num_loci_reg, num_loci_next;
    logic                        cfg_wr;
    logic                        cfg_sel_loci;

    logic                        push_valid;
    logic                        push_ready;
    apd_pkg::apd_item_t          push_item;
    logic                        pop_valid;
    logic                        pop_ready;
    apd_pkg::apd_item_t          pop_item;

    logic [apd_pkg::PROF_W-1:0]  newer_index;
    logic [apd_pkg::PROF_W-1:0]  older_index;
    logic [apd_pkg::DIST_W-1:0]  distance;

    // The register index sits above the byte offset within a 32-bit word.
    assign pready       = 1'b1;
    assign cfg_sel_loci = (paddr[apd_pkg::CFG_AW-1:2] == 1'(apd_pkg::REG_NUM_LOCI));
    assign cfg_wr       = psel && penable && pwrite && pready;

    always_comb begin
        num_loci_next = num_loci_reg;
        if (cfg_wr && cfg_sel_loci) begin
            num_loci_next = pwdata[apd_pkg::NLOCI_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_loci_reg <= apd_pkg::NUM_LOCI_RESET;
        end else begin
            num_loci_reg <= num_loci_next;
        end
    end

    assign prdata = cfg_sel_loci ? 32'(num_loci_reg) : '0;

    apd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .num_loci   (num_loci_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_allele   (s_tdata[apd_pkg::ALLELE_W-1:0]),
        .s_new_set  (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    apd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    apd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_newer_index (newer_index),
        .m_older_index (older_index),
        .m_distance    (distance),
        .m_tlast       (m_tlast)
    );

    assign m_tdata = {distance, older_index, newer_index};

endmodule

// ===== hdl/apd_checker.sv =====
// Port-level checker for the pairwise distance block, bound to the top level.
// Depends on allele_profile_pairwise_distance_assert.svh.
`include "allele_profile_pairwise_distance_assert.svh"

module apd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    logic [5:0]  chk_newer;
    logic [5:0]  chk_older;
    logic [11:0] chk_dist;

    assign chk_newer = m_tdata[5:0];
    assign chk_older = m_tdata[11:6];
    assign chk_dist  = m_tdata[23:12];

    // Every result pairs a profile with an earlier one.
    `APD_ASSERT_SAME(a_older_below_newer, aclk, aresetn, m_tvalid, chk_older < chk_newer)

    // The final result of a profile compares it with the one just before it.
    `APD_ASSERT_SAME(a_last_is_previous, aclk, aresetn, m_tvalid && m_tlast, chk_older + 6'd1 == chk_newer)

    // A distance never exceeds the largest profile length.
    `APD_ASSERT_SAME(a_distance_bound, aclk, aresetn, m_tvalid, chk_dist <= 12'd2048)

    // A stalled result stays offered unchanged.
    `APD_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind allele_profile_pairwise_distance apd_checker u_apd_checker (.*);

// ===== tb/tb_allele_profile_pairwise_distance.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for allele_profile_pairwise_distance: streams allele
// profiles in, predicts every pairwise distance and checks each result transfer.
// Depends on apd_pkg and the RTL of the block; reads no files.
module tb_allele_profile_pairwise_distance;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 8;
    // Pause after the owed distances: room for a full four-entry queue of alleles,
    // each with 63 earlier profiles, to be worked off, with margin.
    localparam int SETTLE_CYCLES   = 300;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int REPORT_MAX      = 10;
    localparam int RANDOM_SETS     = 4;
    localparam int ITEMS_PER_SET   = 40;

    localparam logic [apd_pkg::CFG_AW-1:0] NUM_LOCI_ADDR =
        apd_pkg::CFG_AW'(apd_pkg::REG_NUM_LOCI * 4);

    // One distance result, as the block reports it.
    typedef struct packed {
        logic [apd_pkg::PROF_W-1:0] newer;
        logic [apd_pkg::PROF_W-1:0] older;
        logic [apd_pkg::DIST_W-1:0] distance;
        logic                       last;
    } distance_result_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [apd_pkg::CFG_AW-1:0]  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [31:0]                 s_tdata;   // [30:0] allele, [31] zero
    logic                        s_tuser;   // [0] new_set
    logic                        m_tvalid;
    logic                        m_tready;
    logic [23:0]                 m_tdata;   // [5:0] newer_index, [11:6] older_index,
                                            // [23:12] distance
    logic                        m_tlast;

    // Our own copy of the block's state, advanced once per accepted allele.
    bit [apd_pkg::ALLELE_W-1:0]  allele_store [apd_pkg::STORE_DEPTH];
    int unsigned                 pair_dist [apd_pkg::MAX_PROFILES];
    int unsigned                 profiles_done;
    int unsigned                 next_locus;
    bit [apd_pkg::NLOCI_W-1:0]   loci_setting;

    // Distances still owed by the block, oldest first.
    distance_result_t            pending_distances [$];

    int unsigned                 fail_count  = 0;
    int unsigned                 cycle_count = 0;
    bit                          no_idle;
    bit                          hold_request;

    allele_profile_pairwise_distance i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Distance predictor
    // ------------------------------------------------------------------

    function automatic void clear_data_set();
        foreach (pair_dist[k]) pair_dist[k] = 0;
        profiles_done = 0;
        next_locus    = 0;
    endfunction

    // Advances the predicted state by one allele and queues the distances
    // that the allele releases when it completes a profile.
    function automatic void predict_allele(input bit [30:0] allele, input bit new_set);
        int unsigned loci;
        int unsigned pos;
        int unsigned prof;
        bit [30:0]   stored;
        // Out-of-range settings are clamped: zero acts as one locus, and
        // anything beyond the store depth acts as the full depth.
        if (loci_setting == 0)
            loci = 1;
        else if (loci_setting > apd_pkg::MAX_LOCI)
            loci = apd_pkg::MAX_LOCI;
        else
            loci = loci_setting;
        if (new_set)
            clear_data_set();
        // A shrunken setting can leave the position past the end; the
        // current allele then lands on the last locus and closes the profile.
        pos  = (next_locus >= loci) ? loci - 1 : next_locus;
        prof = profiles_done;
        if (prof < apd_pkg::MAX_PROFILES) begin
            allele_store[prof * apd_pkg::MAX_LOCI + pos] = allele;
            for (int unsigned k = 0; k < prof; k++) begin
                stored = allele_store[k * apd_pkg::MAX_LOCI + pos];
                // Missing alleles (zero) never count as a difference.
                if (allele != 0 && stored != 0 && allele != stored &&
                    pair_dist[k] < apd_pkg::DIST_MAX)
                    pair_dist[k]++;
            end
        end
        if (pos + 1 >= loci) begin
            // Once the store is full, completions release nothing.
            if (prof < apd_pkg::MAX_PROFILES) begin
                for (int unsigned k = 0; k < prof; k++) begin
                    pending_distances.push_back('{newer:    apd_pkg::PROF_W'(prof),
                                                  older:    apd_pkg::PROF_W'(k),
                                                  distance: apd_pkg::DIST_W'(pair_dist[k]),
                                                  last:     (k + 1 == prof)});
                    pair_dist[k] = 0;
                end
                profiles_done = prof + 1;
            end
            next_locus = 0;
        end else begin
            next_locus = pos + 1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking: every transfer on the m_ side is compared with the
    // oldest distance still owed.
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        distance_result_t got;
        distance_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{newer: m_tdata[5:0], older: m_tdata[11:6],
                    distance: m_tdata[23:12], last: m_tlast};
            if (pending_distances.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("%0t: unexpected distance %0d/%0d/%0d/%0b",
                             $realtime, got.newer, got.older, got.distance, got.last);
            end else begin
                want = pending_distances.pop_front();
                if (got.newer !== want.newer || got.older !== want.older ||
                    got.distance !== want.distance || got.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: mismatch: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                                 $realtime, want.newer, want.older, want.distance,
                                 want.last, got.newer, got.older, got.distance, got.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: before each transfer it stalls a random number of
    // cycles. When a test raises hold_request, it holds off for a long
    // stretch instead, so the output backs up into the queue and s_tready
    // drops while the sender keeps offering alleles.
    // ------------------------------------------------------------------

    initial begin : result_sink
        int unsigned stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                stall        = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks. Every task starts and ends at a falling edge.
    // ------------------------------------------------------------------

    // Offers one allele after a random gap and waits for its transfer.
    task automatic send_allele(input bit [30:0] allele, input bit new_set);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, allele};
        s_tuser  <= new_set;
        do @(posedge aclk); while (!s_tready);
        predict_allele(allele, new_set);
        @(negedge aclk);
    endtask

    // Writes num_loci over APB and reads it back.
    task automatic program_num_loci(input bit [apd_pkg::NLOCI_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NUM_LOCI_ADDR;
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        loci_setting = value;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[apd_pkg::NLOCI_W-1:0] !== value) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("%0t: num_loci readback: expected %0d, got %0d",
                         $realtime, value, prdata[apd_pkg::NLOCI_W-1:0]);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drops s_tvalid, waits for every owed distance, then lets the block
    // finish alleles that complete nothing, so that it is idle afterwards.
    task automatic wait_all_distances();
        s_tvalid <= 1'b0;
        while (pending_distances.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Mostly a small alphabet so that equal alleles are common, with missing
    // values, the largest allele and full-width random values mixed in.
    function automatic bit [30:0] pick_allele();
        case ($urandom_range(0, 9))
            0, 1:          return '0;
            2, 3, 4, 5, 6: return 31'($urandom_range(1, 3));
            7:             return 31'h7FFF_FFFF;
            default:       return 31'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The setting 4095 acts as 2048 loci, so ten alleles leave the first
    // profile open. The setting then drops to two: the next allele closes
    // that profile on its last locus and short profiles follow.
    task automatic test_loci_clamp_high();
        program_num_loci(12'hFFF);
        for (int i = 0; i < 10; i++)
            send_allele(pick_allele(), i == 0);
        wait_all_distances();
        program_num_loci(12'd2);
        for (int i = 0; i < 5; i++)
            send_allele(pick_allele(), 1'b0);
        wait_all_distances();
    endtask

    // Hand-picked three-locus profiles: missing against present, equal,
    // differing, and the extremes of the allele range.
    task automatic test_first_profiles();
        program_num_loci(12'd3);
        send_allele(31'd5, 1'b1);
        send_allele('0, 1'b0);
        send_allele(31'h7FFF_FFFF, 1'b0);
        send_allele(31'd5, 1'b0);
        send_allele(31'd9, 1'b0);
        send_allele(31'd1, 1'b0);
        send_allele('0, 1'b0);
        send_allele(31'd9, 1'b0);
        send_allele(31'h7FFF_FFFF, 1'b0);
        send_allele(31'd6, 1'b0);
        send_allele(31'd4, 1'b0);
        send_allele(31'd2, 1'b0);
        wait_all_distances();
    endtask

    // A new data set begins in the middle of a profile: the partial profile
    // is dropped and the flagged allele becomes locus 0 of profile 0.
    task automatic test_new_set_mid_profile();
        for (int i = 0; i < 8; i++)
            send_allele(pick_allele(), i == 0);
        send_allele(pick_allele(), 1'b1);
        for (int i = 0; i < 8; i++)
            send_allele(pick_allele(), 1'b0);
        wait_all_distances();
    endtask

    // The locus count shrinks while a profile is half loaded; the next
    // allele then closes that profile at once.
    task automatic test_loci_shrink_mid_profile();
        program_num_loci(12'd4);
        for (int i = 0; i < 6; i++)
            send_allele(pick_allele(), i == 0);
        wait_all_distances();
        program_num_loci(12'd2);
        for (int i = 0; i < 3; i++)
            send_allele(pick_allele(), 1'b0);
        wait_all_distances();
    endtask

    // A setting of zero acts as one locus per profile.
    task automatic test_loci_zero();
        program_num_loci(12'd0);
        for (int i = 0; i < 5; i++)
            send_allele(pick_allele(), i == 0);
        wait_all_distances();
    endtask

    // One-locus profiles until the store is full; the extra alleles after
    // the 64th profile must release nothing.
    task automatic test_store_full();
        program_num_loci(12'd1);
        for (int i = 0; i < apd_pkg::MAX_PROFILES + 4; i++)
            send_allele(pick_allele(), i == 0);
        wait_all_distances();
    endtask

    // Random data sets. Each starts with new_set right after its setting is
    // written, so no profile is ever read at a locus it never loaded. A few
    // stray new_set flags break profiles off early. The first set runs under
    // the long receiver hold-off, the second without any idling.
    task automatic test_random_sets();
        bit [apd_pkg::NLOCI_W-1:0] loci;
        for (int s = 0; s < RANDOM_SETS; s++) begin
            case (s)
                0:       loci = 12'd1;
                1:       loci = 12'($urandom_range(2, 6));
                2:       loci = 12'($urandom_range(1, 12));
                default: loci = 12'd7;
            endcase
            program_num_loci(loci);
            hold_request = (s == 0);
            no_idle      = (s == 1);
            for (int i = 0; i < ITEMS_PER_SET; i++)
                send_allele(pick_allele(), i == 0 || $urandom_range(0, 19) == 0);
            no_idle = 1'b0;
            wait_all_distances();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        loci_setting = apd_pkg::NUM_LOCI_RESET;
        clear_data_set();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_loci_clamp_high();
        test_first_profiles();
        test_new_set_mid_profile();
        test_loci_shrink_mid_profile();
        test_loci_zero();
        test_store_full();
        test_random_sets();

        wait_all_distances();
        fail_count += pending_distances.size();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/apd_pkg.sv
hdl/apd_ram.sv
hdl/apd_front.sv
hdl/apd_queue.sv
hdl/apd_back.sv
hdl/allele_profile_pairwise_distance.sv
hdl/apd_checker.sv
tb/tb_allele_profile_pairwise_distance.sv
